// ===== rtl/iwak_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iwak_pkg
// shared types and constants of the imu window average and kalman unit
// ----------------------------------------------------------------------------
package iwak_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 40;
    localparam int NOISE_W  = 16;
    localparam int NCHAN    = 6;
    localparam int NAXIS    = 3;

    localparam logic [0:0] REG_PROCESS_NOISE = 1'b0;
    localparam logic [0:0] REG_MEASURE_NOISE = 1'b1;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 16'd1180;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 16'd35521;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t accel_x;
        sample_t accel_y;
        sample_t accel_z;
        sample_t gyro_x;
        sample_t gyro_y;
        sample_t gyro_z;
    } imu_word_t;

    // divider control between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [33:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/iwak_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iwak_if
// valid / ready channel carrying one imu word
// ----------------------------------------------------------------------------
interface iwak_if
    import iwak_pkg::*;
();
    logic      valid;
    logic      ready;
    imu_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/iwak_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iwak_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module iwak_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

`default_nettype wire

// ===== rtl/iwak_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iwak_div
// restoring divider, one quotient bit per cycle, 33 bit quotient
// ----------------------------------------------------------------------------
module iwak_div
    import iwak_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0] num_reg;
    logic [33:0] den_reg;
    logic [34:0] rem_reg;
    logic [32:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] trial;

    assign trial = {rem_reg[33:0], num_reg[32]} - {1'b0, den_reg};
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator below 2^63; upper 31 bits are preloaded as remainder,
    // the low 33 bits are shifted in from bit 32
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            rem_reg <= {4'b0, req.num[63:33]};
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            if (!trial[34])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[33:0], num_reg[32]};
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
        end
    end
endmodule

`default_nettype wire

// ===== rtl/imu_window_average_kalman_unit.sv =====
`default_nettype none
// imu window average with scalar kalman filter on the accel axes
// from accepted word to result valid: six history read-modify-writes, each a read, a write,
// a reciprocal multiply and an average; three kalman steps, each around a gain division;
// then the move into the output register
// no new word is taken until then; a result held by the sink stalls the next word at its last step
// reset: registers to defaults, history of 6 * WINDOW entries cleared, no word taken meanwhile
// ----------------------------------------------------------------------------
// imu_window_average_kalman_unit
// windowed averages, kalman filtered accel, offset snapped gyro
// ----------------------------------------------------------------------------
module imu_window_average_kalman_unit
    import iwak_pkg::*;
#(
    parameter int WINDOW     = 100,
    parameter int SNAP_LIMIT = 50,
    parameter int FRAC_BITS  = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    iwak_if.sink              in_ch,
    iwak_if.source            out_ch,
    input  wire               cfg_we,
    input  wire  [0:0]        cfg_index,
    input  wire  [NOISE_W-1:0] cfg_wdata
);
    localparam int DEPTH  = NCHAN * WINDOW;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(WINDOW);
    // reciprocal for division of the window sum by WINDOW
    localparam int RSH    = 48;
    localparam logic [48:0] RECIP = 49'((64'd1 << RSH) / WINDOW + 64'd1);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_WR    = 11'b00000001000,
        S_AVG   = 11'b00000010000,
        S_AVG2  = 11'b00000100000,
        S_KDIV  = 11'b00001000000,
        S_KWAIT = 11'b00010000000,
        S_KUPD  = 11'b00100000000,
        S_KUPD2 = 11'b01000000000,
        S_PUSH  = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [NOISE_W-1:0] q_reg, r_reg;
    logic [AW-1:0]      clr_reg;
    logic [PW-1:0]      pos_reg;
    logic [2:0]         ch_reg;
    imu_word_t          in_reg;
    logic signed [SUM_W-1:0] sum_reg [NCHAN];
    logic signed [SUM_W-1:0] avg_reg [NCHAN];
    logic signed [SAMPLE_W-1:0] est_reg [NAXIS];
    logic [31:0]        cov_reg [NAXIS];
    logic signed [7:0]  off_reg [NAXIS];
    logic [32:0]        pp_reg;
    logic [32:0]        pp_sat;
    logic [32:0]        k_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [65:0]        prod_reg;
    logic [65:0]        pprod_reg;
    logic [SUM_W-1:0]   amag_reg;
    logic               aneg_reg;
    logic [1:0]         mcnt_reg;
    logic [88:0]        acc_reg;
    logic [88:0]        acc_next;
    logic [19:0]        mul_a;
    logic [24:0]        mul_b;
    logic [44:0]        mul_p;
    logic               out_valid_reg;
    logic               push_go;
    sample_t            out_reg [NCHAN];
    sample_t            res_reg [NCHAN];

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
    div_req_t           dreq;
    div_rsp_t           drsp;
    sample_t            sel_in;
    logic [1:0]         ax;

    iwak_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_hist (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    iwak_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign ax = ch_reg[1:0];

    always_comb
    begin
        case (ch_reg)
            3'd0:    sel_in = in_reg.accel_x;
            3'd1:    sel_in = in_reg.accel_y;
            3'd2:    sel_in = in_reg.accel_z;
            3'd3:    sel_in = in_reg.gyro_x;
            3'd4:    sel_in = in_reg.gyro_y;
            default: sel_in = in_reg.gyro_z;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = sel_in;
        ram_addr  = AW'(32'(ch_reg) * WINDOW + 32'(pos_reg));
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            ram_addr  = clr_reg;
        end
        else if (state_reg == S_WR)
        begin
            ram_we = 1'b1;
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = {out_reg[0], out_reg[1], out_reg[2],
                           out_reg[3], out_reg[4], out_reg[5]};

    assign push_go = (state_reg == S_PUSH) && (!out_valid_reg || out_ch.ready);

    assign dreq.start = (state_reg == S_KDIV);
    assign dreq.num   = {pp_sat, 31'b0};
    assign dreq.den   = {1'b0, pp_sat} + {3'b0, r_reg, 15'b0};

    // one 20 x 25 partial product of |sum| * RECIP per cycle
    always_comb
    begin
        mul_a = mcnt_reg[1] ? amag_reg[39:20] : amag_reg[19:0];
        mul_b = mcnt_reg[0] ? RECIP[48:24] : {1'b0, RECIP[23:0]};
        mul_p = 45'(mul_a) * 45'(mul_b);
        case (mcnt_reg)
            2'd0:    acc_next = acc_reg + 89'(mul_p);
            2'd1:    acc_next = acc_reg + (89'(mul_p) << 24);
            2'd2:    acc_next = acc_reg + (89'(mul_p) << 20);
            default: acc_next = acc_reg + (89'(mul_p) << 44);
        endcase
    end

    // offset removal and saturation of the gyro output of one axis
    function automatic sample_t gyro_out(input logic signed [SUM_W-1:0] avg,
                                         input logic signed [7:0] off);
        logic signed [SUM_W+1:0] d;
        begin
            d = {{2{avg[SUM_W-1]}}, avg} - ((SUM_W+2)'(off) <<< FRAC_BITS);
            if (d > (SUM_W+2)'(64'sh7FFFFFFF))
                gyro_out = 32'sh7FFFFFFF;
            else if (d < -(SUM_W+2)'(64'sh80000000))
                gyro_out = 32'sh80000000;
            else
                gyro_out = d[31:0];
        end
    endfunction

    logic signed [SUM_W-1:0] new_sum;
    assign new_sum = sum_reg[ch_reg] + SUM_W'(sel_in) - SUM_W'($signed(ram_rdata));

    logic signed [SAMPLE_W:0] diff;
    assign diff = {avg_reg[ax][SUM_W-1], avg_reg[ax][31:0]}
                - {est_reg[ax][31], est_reg[ax]};

    logic [32:0] delta;
    assign delta = (prod_reg + 66'(1 << 30)) >> 31 > 66'(mag_reg) ? mag_reg
                 : 33'((prod_reg + 66'(1 << 30)) >> 31);

    logic [32:0] pp_sum;
    assign pp_sum = {1'b0, cov_reg[ax]} + {2'b0, q_reg, 15'b0};
    assign pp_sat = pp_sum[32] ? 33'h0FFFFFFFF : pp_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            q_reg         <= PROCESS_NOISE_RST;
            r_reg         <= MEASURE_NOISE_RST;
            clr_reg       <= '0;
            pos_reg       <= '0;
            ch_reg        <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCHAN; i++)
            begin
                sum_reg[i] <= '0;
            end
            for (int i = 0; i < NAXIS; i++)
            begin
                est_reg[i] <= '0;
                cov_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE: q_reg <= cfg_wdata;
                    REG_MEASURE_NOISE: r_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // finished word moves to the output register once it is free
            if (push_go)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NCHAN; i++)
                begin
                    out_reg[i] <= res_reg[i];
                end
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        in_reg    <= in_ch.data;
                        ch_reg    <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_WR;
                S_WR:
                begin
                    sum_reg[ch_reg] <= new_sum;
                    aneg_reg <= new_sum[SUM_W-1];
                    amag_reg <= new_sum[SUM_W-1] ? -new_sum : new_sum;
                    acc_reg  <= '0;
                    mcnt_reg <= '0;
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    // four partial products accumulated, then the truncated quotient
                    acc_reg  <= acc_next;
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                    begin
                        amag_reg  <= SUM_W'(acc_next >> RSH);
                        state_reg <= S_AVG2;
                    end
                end
                S_AVG2:
                begin
                    avg_reg[ch_reg] <= aneg_reg ? -amag_reg : amag_reg;
                    if (ch_reg == 3'd5)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_KDIV;
                        pos_reg   <= (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + PW'(1);
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 3'd1;
                        state_reg <= S_RD;
                    end
                end
                S_KDIV:
                begin
                    state_reg <= S_KWAIT;
                end
                S_KWAIT:
                begin
                    if (drsp.done)
                    begin
                        k_reg     <= (dreq.den == '0) ? '0 : drsp.quo;
                        neg_reg   <= diff[SAMPLE_W];
                        mag_reg   <= diff[SAMPLE_W] ? 33'(-diff) : 33'(diff);
                        state_reg <= S_KUPD;
                    end
                end
                S_KUPD:
                begin
                    prod_reg  <= 66'(k_reg) * 66'(mag_reg);
                    pprod_reg <= 66'(33'h080000000 - k_reg) * 66'(pp_reg);
                    state_reg <= S_KUPD2;
                end
                S_KUPD2:
                begin
                    est_reg[ax] <= neg_reg ? est_reg[ax] - SAMPLE_W'(delta)
                                           : est_reg[ax] + SAMPLE_W'(delta);
                    cov_reg[ax] <= 32'((pprod_reg + 66'(1 << 30)) >> 31);
                    res_reg[ch_reg] <= neg_reg ? est_reg[ax] - SAMPLE_W'(delta)
                                               : est_reg[ax] + SAMPLE_W'(delta);
                    if (ch_reg == 3'd2)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_PUSH;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 3'd1;
                        state_reg <= S_KDIV;
                    end
                end
                S_PUSH:
                begin
                    if (push_go)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            // gyro snap once the averages are complete
            if (state_reg == S_KDIV && ch_reg == 3'd0)
            begin
                for (int i = 0; i < NAXIS; i++)
                begin
                    logic signed [SUM_W-1:0] a;
                    logic [SUM_W-1:0] m;
                    logic signed [7:0] o;
                    a = avg_reg[i+3];
                    m = a[SUM_W-1] ? -a : a;
                    o = off_reg[i];
                    if (sum_reg[i+3] == a * WINDOW
                        && m[FRAC_BITS-1:0] == '0
                        && (m >> FRAC_BITS) < SUM_W'(SNAP_LIMIT))
                    begin
                        o = a[SUM_W-1] ? -8'(m >> FRAC_BITS) : 8'(m >> FRAC_BITS);
                    end
                    off_reg[i]   <= o;
                    res_reg[i+3] <= gyro_out(a, o);
                end
            end
        end
    end

    // predicted covariance held for the covariance update
    always_ff @(posedge clk)
    begin
        if (state_reg == S_KDIV)
        begin
            pp_reg <= pp_sat;
        end
    end
endmodule

`default_nettype wire

// ===== verif/tb_imu_window_average_kalman_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_window_average_kalman_unit
// drives imu words through the unit and checks every result against a
// cycle-free prediction of the window averages, kalman estimates and gyro
// offset snapping, under random idling, a long output stall and noise changes
// ----------------------------------------------------------------------------
module tb_imu_window_average_kalman_unit;
    import iwak_pkg::*;

    localparam int WINDOW     = 100;
    localparam int SNAP_LIMIT = 50;
    localparam int FRAC_BITS  = 16;
    localparam int SETTLE     = 200;
    localparam int WDOG_LIMIT = 6000;
    localparam int STALL_LEN  = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_PROCESS_NOISE;
    logic [NOISE_W-1:0] cfg_wdata = '0;

    iwak_if in_if ();
    iwak_if out_if ();

    imu_window_average_kalman_unit #(
        .WINDOW(WINDOW),
        .SNAP_LIMIT(SNAP_LIMIT),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if.sink),
        .out_ch(out_if.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [NOISE_W-1:0] q_noise = PROCESS_NOISE_RST;
    logic [NOISE_W-1:0] r_noise = MEASURE_NOISE_RST;
    longint history [NCHAN][WINDOW];
    longint chan_sum [NCHAN];
    longint estimate [NAXIS];
    longint unsigned covariance [NAXIS];
    longint offset [NAXIS];
    int     hist_pos = 0;

    imu_word_t filtered_words [$];
    int  errors = 0;
    bit  no_idle = 1'b0;
    bit  stall_req = 1'b0;
    int  idle_cycles = 0;

    initial
    begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        for (int c = 0; c < NCHAN; c++)
        begin
            chan_sum[c] = 0;
            for (int i = 0; i < WINDOW; i++)
                history[c][i] = 0;
        end
        for (int a = 0; a < NAXIS; a++)
        begin
            estimate[a] = 0;
            covariance[a] = 0;
            offset[a] = 0;
        end
    end

    function automatic longint field_of(imu_word_t w, int c);
        sample_t s;
        s = w[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W];
        return longint'(s);
    endfunction

    function automatic longint kalman_next(int a, longint avg);
        longint unsigned pp, den, k, mag, delta;
        longint diff;
        pp = covariance[a] + (longint'(q_noise) << 15);
        if (pp > 64'hFFFF_FFFF)
            pp = 64'hFFFF_FFFF;
        den = pp + (longint'(r_noise) << 15);
        k = (den == 0) ? 0 : (pp << 31) / den;
        diff = avg - estimate[a];
        mag = (diff < 0) ? longint'(-diff) : longint'(diff);
        delta = (k * mag + (64'd1 << 30)) >> 31;
        if (delta > mag)
            delta = mag;
        estimate[a] = (diff < 0) ? estimate[a] - longint'(delta) : estimate[a] + longint'(delta);
        covariance[a] = ((((64'd1 << 31) - k) * pp) + (64'd1 << 30)) >> 31;
        covariance[a] = covariance[a] & 64'hFFFF_FFFF;
        return estimate[a];
    endfunction

    function automatic longint gyro_next(int a, longint sum, longint avg);
        longint unsigned mag;
        longint res;
        mag = (avg < 0) ? longint'(-avg) : longint'(avg);
        if ((sum % WINDOW) == 0 && mag[FRAC_BITS-1:0] == 0 && (mag >> FRAC_BITS) < SNAP_LIMIT)
            offset[a] = (avg < 0) ? -longint'(mag >> FRAC_BITS) : longint'(mag >> FRAC_BITS);
        res = avg - offset[a] * (longint'(1) << FRAC_BITS);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res;
    endfunction

    function automatic imu_word_t filter_word(imu_word_t w);
        longint avg [NCHAN];
        longint s;
        imu_word_t r;
        for (int c = 0; c < NCHAN; c++)
        begin
            s = field_of(w, c);
            chan_sum[c] = chan_sum[c] + s - history[c][hist_pos];
            history[c][hist_pos] = s;
            avg[c] = chan_sum[c] / WINDOW;
        end
        hist_pos = (hist_pos + 1) % WINDOW;
        for (int a = 0; a < NAXIS; a++)
        begin
            r[(NCHAN-1-a)*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(kalman_next(a, avg[a]));
            r[(NAXIS-1-a)*SAMPLE_W +: SAMPLE_W] =
                SAMPLE_W'(gyro_next(a, chan_sum[a+3], avg[a+3]));
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // picks a raw sample that lands the window sum on an exact integer average, else a random one
    function automatic sample_t snap_sample(int c, int n);
        longint want, s;
        want = longint'(n) * WINDOW * (longint'(1) << FRAC_BITS);
        s = want - (chan_sum[c] - history[c][hist_pos]);
        if (s > 64'sd2147483647 || s < -64'sd2147483648)
            return sample_t'($urandom);
        return sample_t'(s);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return sample_t'($urandom_range(0, 1023)) - 32'sd512;
            3: return sample_t'($urandom_range(0, 40) - 20) <<< FRAC_BITS;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic imu_word_t rand_word();
        imu_word_t w;
        for (int c = 0; c < NCHAN; c++)
        begin
            if (c >= 3 && $urandom_range(0, 9) < 3)
                w[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W] =
                    snap_sample(c, $urandom_range(0, 2*SNAP_LIMIT + 4) - SNAP_LIMIT - 2);
            else
                w[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W] = rand_sample();
        end
        return w;
    endfunction

    task automatic send_word(imu_word_t w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= w;
        do
            @(posedge clk);
        while (!in_if.ready);
        filtered_words.push_back(filter_word(w));
    endtask

    task automatic end_burst();
        in_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (filtered_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_noise(logic [0:0] idx, logic [NOISE_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PROCESS_NOISE)
            q_noise = v;
        else
            r_noise = v;
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_word(rand_word());
        end_burst();
    endtask

    function automatic imu_word_t gyro_word(sample_t g);
        imu_word_t w;
        w = '0;
        w.gyro_x = g;
        w.gyro_y = -g;
        w.gyro_z = g;
        return w;
    endfunction

    task automatic test_directed();
        imu_word_t w;
        no_idle = 1'b1;
        w = '0;
        send_word(w);
        w = {NCHAN{32'sh7FFF_FFFF}};
        send_word(w);
        w = {NCHAN{32'sh8000_0000}};
        send_word(w);
        w = {NCHAN{32'shFFFF_FFFF}};
        send_word(w);
        w = {NCHAN{32'sh5555_5555}};
        send_word(w);
        w = {NCHAN{32'shAAAA_AAAA}};
        send_word(w);
        // exact integer averages, the edge of the snap range, and zero
        send_word(gyro_word(snap_sample(3, 5)));
        send_word(gyro_word(snap_sample(3, SNAP_LIMIT - 1)));
        send_word(gyro_word(snap_sample(3, SNAP_LIMIT)));
        send_word(gyro_word(snap_sample(3, 0)));
        // average off an integer by one count
        send_word(gyro_word(snap_sample(3, 3) + 32'sd1));
        // large negative offset, then runs of full-scale positive and negative samples
        send_word(gyro_word(snap_sample(3, -(SNAP_LIMIT - 1))));
        for (int i = 0; i < 6; i++)
            send_word({NCHAN{32'sh7FFF_FFFF}});
        for (int i = 0; i < 6; i++)
            send_word({NCHAN{32'sh8000_0000}});
        end_burst();
        no_idle = 1'b0;
    endtask

    task automatic test_noise_extremes();
        write_noise(REG_PROCESS_NOISE, 16'd0);
        write_noise(REG_MEASURE_NOISE, 16'd0);
        send_random(20);
        write_noise(REG_PROCESS_NOISE, 16'hFFFF);
        send_random(20);
        write_noise(REG_MEASURE_NOISE, 16'hFFFF);
        send_random(20);
        write_noise(REG_PROCESS_NOISE, 16'd0);
        send_random(20);
    endtask

    task automatic test_back_pressure();
        write_noise(REG_PROCESS_NOISE, PROCESS_NOISE_RST);
        write_noise(REG_MEASURE_NOISE, MEASURE_NOISE_RST);
        stall_req = 1'b1;
        send_random(40);
        stall_req = 1'b0;
        // sender pauses until everything has come back
        while (filtered_words.size() != 0)
            @(posedge clk);
        send_random(20);
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++)
        begin
            no_idle = (p == 2);
            write_noise(REG_PROCESS_NOISE, NOISE_W'($urandom));
            write_noise(REG_MEASURE_NOISE, NOISE_W'($urandom));
            send_random(50);
        end
        no_idle = 1'b0;
    endtask

    // result side: random ready, with one long hold-off on request
    initial
    begin
        int g;
        bit stalled;
        stalled = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_req && !stalled)
            begin
                stalled = 1'b1;
                out_if.ready <= 1'b0;
                repeat (STALL_LEN) @(posedge clk);
            end
            g = gap_len();
            if (g > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        imu_word_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (filtered_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, out_if.data);
                errors++;
            end
            else
            begin
                want = filtered_words.pop_front();
                for (int c = 0; c < NCHAN; c++)
                    if (want[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W] !==
                        out_if.data[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W])
                    begin
                        $display("%0t: field %0d expected %h actual %h", $time, c,
                                 want[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W],
                                 out_if.data[(NCHAN-1-c)*SAMPLE_W +: SAMPLE_W]);
                        errors++;
                    end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_noise_extremes();
        test_back_pressure();
        test_random();
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
